@@ sv/assert_macros.svh @@
// Assertion macros shared by the page frame allocator RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property that must also hold during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ sv/rpfa_pkg.sv @@
// Shared types and constants for the refcounted page frame allocator.
// No dependencies.
`default_nettype none
package rpfa_pkg;
  localparam int unsigned FRAMES     = 4096;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned FW  = $clog2(FRAMES);
  localparam int unsigned CW  = FW + 1;
  localparam int unsigned PW  = $clog2(PAGE_BYTES);
  localparam int unsigned EW  = 16;
  localparam logic [EW-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    FN_ALLOC   = 3'd0,
    FN_RETAIN  = 3'd1,
    FN_RELEASE = 3'd2,
    FN_QUERY   = 3'd3,
    FN_AVAIL   = 3'd4,
    FN_RESERVE = 3'd5,
    FN_SNAP    = 3'd6,
    FN_HINT    = 3'd7
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] address;
    logic [32:0] range_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0]   page_address;
    logic          status;
    logic [15:0]   ref_count;
    logic [12:0]   free_count;
    logic [12:0]   usable_total;
    logic [12:0]   managed_frames;
  } out_item_t;

  typedef struct packed {
    logic          used;
    logic [EW-1:0] cnt;
  } entry_t;
endpackage
`default_nettype wire

@@ sv/rpfa_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module rpfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ sv/refcounted_page_frame_allocator_unit.sv @@
// Refcounted page frame allocator: one frame table entry {used, 16-bit count} per
// frame in a single-port RAM; depends on rpfa_pkg, rpfa_ram and assert_macros.svh.
// After reset a clearing pass writes every entry to used with count 1 (no beat
// taken). Each beat is handled alone: retain, release and query read the entry and
// then check or update it, snapshot and set hint go straight to the result; alloc
// scans the entries one at a time from the hint (and then from frame 0 to the hint);
// range beats visit every frame of the range. One RAM port serves every read and write.
// A result waits in the output register while the next beat is already taken.
`default_nettype none
module refcounted_page_frame_allocator_unit
  import rpfa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
`include "assert_macros.svh"

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MOD   = 7'b0001000,
    S_DONE  = 7'b0010000,
    S_SCANR = 7'b0100000,
    S_SCANM = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  func_t  func_r, func_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] last_r, last_nxt;
  logic [CW-1:0] limit_r, limit_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [CW-1:0] snap_r, snap_nxt;
  logic [CW-1:0] hint_r, hint_nxt;
  logic          wrap_r, wrap_nxt;
  logic          stat_r, stat_nxt;
  logic [EW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   page_r, page_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          we;
  logic [FW-1:0] ram_addr;
  entry_t        wdata, rdata;

  rpfa_ram #(.WIDTH(EW + 1), .DEPTH(FRAMES)) u_ram (
    .clk  (clk),
    .we   (we),
    .addr (ram_addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  localparam logic [32:0] TOP = 33'(FRAMES) << PW;

  logic [32:0] rend_clip;
  logic [32:0] a_frm_ceil, e_frm_ceil, a_frm_floor;
  logic        chk_ok;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    rend_clip   = (in_data.range_end > TOP) ? TOP : in_data.range_end;
    a_frm_ceil  = (33'(in_data.address) + 33'(PAGE_BYTES - 1)) >> PW;
    e_frm_ceil  = (rend_clip + 33'(PAGE_BYTES - 1)) >> PW;
    a_frm_floor = 33'(in_data.address) >> PW;
  end

  assign chk_ok = (addr_r[PW-1:0] == '0) && ((33'(addr_r) >> PW) < 33'(limit_r))
                  && rdata.used && (rdata.cnt != '0);

  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r;
    addr_nxt = addr_r;
    cur_nxt = cur_r;
    last_nxt = last_r;
    limit_nxt = limit_r;
    free_nxt = free_r;
    snap_nxt = snap_r;
    hint_nxt = hint_r;
    wrap_nxt = wrap_r;
    stat_nxt = stat_r;
    cnt_nxt = cnt_r;
    page_nxt = page_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    we = 1'b0;
    ram_addr = cur_r[FW-1:0];
    wdata = '{used: 1'b1, cnt: EW'(1)};
    in_stall = 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        cur_nxt = cur_r + 1'b1;
        if (cur_r == CW'(FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          func_nxt = func_t'(in_data.func);
          addr_nxt = in_data.address;
          stat_nxt = 1'b0;
          cnt_nxt = '0;
          page_nxt = '0;
          wrap_nxt = 1'b0;
          case (func_t'(in_data.func))
            FN_ALLOC: begin
              cur_nxt = hint_r;
              last_nxt = limit_r;
              state_nxt = S_SCANR;
            end
            FN_RETAIN, FN_RELEASE, FN_QUERY: begin
              cur_nxt = CW'(in_data.address >> PW);
              state_nxt = S_READ;
            end
            FN_AVAIL: begin
              cur_nxt = (a_frm_ceil > 33'(FRAMES)) ? CW'(FRAMES) : CW'(a_frm_ceil);
              last_nxt = CW'(rend_clip >> PW);
              if (CW'(rend_clip >> PW) > limit_r) begin
                limit_nxt = CW'(rend_clip >> PW);
              end
              state_nxt = S_SCANR;
            end
            FN_RESERVE: begin
              cur_nxt = (a_frm_floor > 33'(FRAMES)) ? CW'(FRAMES) : CW'(a_frm_floor);
              last_nxt = (e_frm_ceil > 33'(limit_r)) ? limit_r : CW'(e_frm_ceil);
              state_nxt = S_SCANR;
            end
            FN_SNAP: begin
              snap_nxt = free_r;
              state_nxt = S_DONE;
            end
            default: begin
              hint_nxt = (a_frm_ceil > 33'(FRAMES)) ? CW'(FRAMES) : CW'(a_frm_ceil);
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (addr_r >= 32'(FRAMES) << PW) begin
          stat_nxt = 1'b1;
        end else if (!chk_ok) begin
          stat_nxt = 1'b1;
        end else begin
          case (func_r)
            FN_RETAIN: begin
              if (rdata.cnt == CNT_MAX) begin
                stat_nxt = 1'b1;
              end else begin
                we = 1'b1;
                wdata = '{used: 1'b1, cnt: rdata.cnt + 1'b1};
              end
            end
            FN_RELEASE: begin
              we = 1'b1;
              wdata = '{used: (rdata.cnt != EW'(1)), cnt: rdata.cnt - 1'b1};
              if (rdata.cnt == EW'(1)) begin
                free_nxt = free_r + 1'b1;
                if (cur_r < hint_r) begin
                  hint_nxt = cur_r;
                end
              end
            end
            default: begin
              cnt_nxt = rdata.cnt;
            end
          endcase
        end
        state_nxt = S_DONE;
      end
      S_SCANR: begin
        if (cur_r >= last_r || cur_r >= CW'(FRAMES)) begin
          if (func_r == FN_ALLOC && !wrap_r) begin
            wrap_nxt = 1'b1;
            cur_nxt = '0;
            last_nxt = hint_r;
          end else begin
            if (func_r == FN_ALLOC) begin
              stat_nxt = 1'b1;
            end
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_SCANM;
        end
      end
      S_SCANM: begin
        state_nxt = S_SCANR;
        cur_nxt = cur_r + 1'b1;
        case (func_r)
          FN_ALLOC: begin
            if (!rdata.used) begin
              we = 1'b1;
              free_nxt = free_r - 1'b1;
              hint_nxt = cur_r + 1'b1;
              page_nxt = 32'(cur_r) << PW;
              state_nxt = S_DONE;
            end
          end
          FN_AVAIL: begin
            if (rdata.used) begin
              we = 1'b1;
              wdata = '{used: 1'b0, cnt: '0};
              free_nxt = free_r + 1'b1;
            end
          end
          default: begin
            if (!rdata.used) begin
              we = 1'b1;
              free_nxt = free_r - 1'b1;
            end
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.page_address = page_r;
          out_nxt.status = stat_r;
          out_nxt.ref_count = cnt_r;
          out_nxt.free_count = 13'(free_r);
          out_nxt.usable_total = 13'(snap_r);
          out_nxt.managed_frames = 13'(limit_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cur_r <= '0;
      limit_r <= '0;
      free_r <= '0;
      snap_r <= '0;
      hint_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r <= cur_nxt;
      limit_r <= limit_nxt;
      free_r <= free_nxt;
      snap_r <= snap_nxt;
      hint_r <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    addr_r <= addr_nxt;
    last_r <= last_nxt;
    wrap_r <= wrap_nxt;
    stat_r <= stat_nxt;
    cnt_r <= cnt_nxt;
    page_r <= page_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `ASSERT_CLK(a_free_bound, clk, rst_n, free_r <= CW'(FRAMES), "free count exceeds frames")
  `ASSERT_CLK(a_hint_bound, clk, rst_n, hint_r <= CW'(FRAMES), "hint beyond frames")
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid_r && out_stall) |=> $stable(out_r), "result changed while stalled")
  `ASSERT_CLK(a_no_take_busy, clk, rst_n, (state_r != S_IDLE) |-> in_stall, "beat taken while busy")
endmodule
`default_nettype wire
